// ===== rtl/ist_pkg.sv =====
package ist_pkg;

   // Table size and the widths that follow from it.
   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Field widths of the request and response items.
   localparam int ACTION_W   = 2;
   localparam int ELEMENT_W  = 32;
   localparam int POSITION_W = 4;
   localparam int STATUS_W   = 2;
   localparam int OCC_W      = 5;

   // Bus widths.
   localparam int REQ_DATA_W = 32;
   localparam int REQ_USER_W = ACTION_W;
   localparam int RSP_DATA_W = 16;
   localparam int RSP_USER_W = 1 + STATUS_W;

   typedef logic signed [ELEMENT_W-1:0] element_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOOKUP = 2'd0,
      ACT_INSERT = 2'd1,
      ACT_REMOVE = 2'd2
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE      = 2'd0,
      ST_UNCHANGED = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MATCH,
      S_UPDATE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic match;
      logic update;
   } cmd_type;

endpackage

// ===== rtl/ist_ctrl.sv =====
module ist_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output ist_pkg::cmd_type cmd
);
   import ist_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      out_valid_ff;
   logic      out_valid_in;
   logic      out_free;
   logic      accept;

   // The result register can take a new item when empty or being drained.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign rsp_tvalid = out_valid_ff;

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      req_tready   = 1'b0;
      cmd          = '0;
      out_valid_in = out_valid_ff && !rsp_tready;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
         end
         S_MATCH: begin
            cmd.match = 1'b1;
            state_in  = S_UPDATE;
         end
         S_UPDATE: begin
            if (out_free) begin
               cmd.update   = 1'b1;
               out_valid_in = 1'b1;
               req_tready   = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      accept   = req_tvalid && req_tready;
      cmd.load = accept;
      if (accept) begin
         state_in = S_MATCH;
      end
   end

   // State and result-valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// ===== rtl/ist_datapath.sv =====
module ist_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  ist_pkg::cmd_type            cmd,
   input  logic [ist_pkg::ACTION_W-1:0] req_action,
   input  ist_pkg::element_type        req_element,
   output logic                        rsp_found,
   output logic [ist_pkg::POSITION_W-1:0] rsp_position,
   output ist_pkg::status_type         rsp_status,
   output logic [ist_pkg::OCC_W-1:0]   rsp_occupancy
);
   import ist_pkg::*;

   logic [ACTION_W-1:0] action_ff;
   element_type         element_ff;
   logic [CAPACITY-1:0] match_ff;
   logic [CAPACITY-1:0] match_in;
   element_type         entries_ff [CAPACITY];
   element_type         entries_in [CAPACITY];
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;

   logic                found_ff;
   logic [POSITION_W-1:0] position_ff;
   status_type          status_ff;
   logic [OCC_W-1:0]    occ_ff;

   logic                hit;
   logic [IDX_W-1:0]    pos;
   logic [CAPACITY-1:0] past_hit;
   logic                ins_ok;
   logic                do_remove;
   status_type          status_in;

   // Compare every live entry with the request in parallel.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         match_in[i] = (CNT_W'(i) < count_ff) && (entries_ff[i] == element_ff);
      end
   end

   // Lowest matching index and the run of entries at or above it.
   always_comb begin
      hit = |match_ff;
      pos = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            pos = IDX_W'(i);
         end
      end
      past_hit[0] = match_ff[0];
      for (int i = 1; i < CAPACITY; i++) begin
         past_hit[i] = past_hit[i-1] || match_ff[i];
      end
   end

   // Decide the update from the action and the lookup result.
   always_comb begin
      ins_ok    = 1'b0;
      do_remove = 1'b0;
      status_in = ST_DONE;
      count_in  = count_ff;
      case (action_ff)
         ACT_INSERT: begin
            if (hit) begin
               status_in = ST_UNCHANGED;
            end else if (count_ff >= CNT_W'(CAPACITY)) begin
               status_in = ST_FULL;
            end else begin
               ins_ok   = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         ACT_REMOVE: begin
            if (!hit) begin
               status_in = ST_UNCHANGED;
            end else begin
               do_remove = 1'b1;
               count_in  = count_ff - 1'b1;
            end
         end
         default: begin
            status_in = ST_DONE;
         end
      endcase
   end

   // Next table contents: append at the tail or close the gap of a removal.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         entries_in[i] = entries_ff[i];
         if (ins_ok && (count_ff == CNT_W'(i))) begin
            entries_in[i] = element_ff;
         end
      end
      for (int i = 0; i < CAPACITY - 1; i++) begin
         if (do_remove && past_hit[i] && (CNT_W'(i + 1) < count_ff)) begin
            entries_in[i] = entries_ff[i+1];
         end
      end
   end

   // Live count.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.update) begin
         count_ff <= count_in;
      end
   end

   // Request, match and table registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff  <= req_action;
         element_ff <= req_element;
      end
      if (cmd.match) begin
         match_ff <= match_in;
      end
      if (cmd.update) begin
         entries_ff <= entries_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         found_ff    <= hit;
         position_ff <= POSITION_W'(pos);
         status_ff   <= status_in;
         occ_ff      <= OCC_W'(count_in);
      end
   end

   assign rsp_found     = found_ff;
   assign rsp_position  = position_ff;
   assign rsp_status    = status_ff;
   assign rsp_occupancy = occ_ff;

endmodule

// ===== rtl/integer_set_table.sv =====
// Flow: an accepted request item is registered, the match state registers the parallel
// compare across the register table, and the update state inserts into or shifts that
// table and writes the result, waiting while an earlier result is stalled. A new request
// is taken in the idle state or as the update state completes, never during the compare.
// Reset: the live count clears and no result is pending; table entries hold no value
// until written.
module integer_set_table (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ist_pkg::REQ_DATA_W-1:0]  req_tdata,   // [31:0] element
   input  logic [ist_pkg::REQ_USER_W-1:0]  req_tuser,   // [1:0] action
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ist_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // [3:0] position, [8:4] occupancy
   output logic [ist_pkg::RSP_USER_W-1:0]  rsp_tuser    // [0] found, [2:1] status
);
   import ist_pkg::*;

   cmd_type               cmd;
   logic                  found;
   logic [POSITION_W-1:0] position;
   status_type            status;
   logic [OCC_W-1:0]      occupancy;

   ist_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   ist_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_action    (req_tuser[ACTION_W-1:0]),
      .req_element   (element_type'(req_tdata[ELEMENT_W-1:0])),
      .rsp_found     (found),
      .rsp_position  (position),
      .rsp_status    (status),
      .rsp_occupancy (occupancy)
   );

   // Pack the result item onto the bus.
   assign rsp_tdata = {{(RSP_DATA_W - POSITION_W - OCC_W){1'b0}}, occupancy, position};
   assign rsp_tuser = {status, found};

endmodule

// ===== rtl/ist_checker.sv =====
module ist_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [ist_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic [ist_pkg::RSP_USER_W-1:0]  rsp_tuser
);
   import ist_pkg::*;

   // A stalled result holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // Occupancy never exceeds the table size.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[8:4] <= OCC_W'(CAPACITY))
      else $error("occupancy above capacity");

   // A full refusal only happens for an absent value in a full table.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[2:1] == ST_FULL) |->
         !rsp_tuser[0] && (rsp_tdata[8:4] == OCC_W'(CAPACITY)))
      else $error("full status without a full table");

   // A hit lies at or below the reported occupancy, a miss reports position zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[0] && (OCC_W'(rsp_tdata[3:0]) <= rsp_tdata[8:4])) ||
                     (!rsp_tuser[0] && (rsp_tdata[3:0] == '0)))
      else $error("position inconsistent with found");

   // No new request is taken while the previous one is still being compared.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted during compare");

endmodule

bind integer_set_table ist_checker u_ist_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== sim/set_table_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels of the set table, keeps its own copy of the table
// and compares every response item with the oldest predicted one.
module set_table_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [ist_pkg::REQ_DATA_W-1:0] req_tdata,   // [31:0] element
   input  logic [ist_pkg::REQ_USER_W-1:0] req_tuser,   // [1:0] action
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [ist_pkg::RSP_DATA_W-1:0] rsp_tdata,   // [3:0] position, [8:4] occupancy
   input  logic [ist_pkg::RSP_USER_W-1:0] rsp_tuser,   // [0] found, [2:1] status
   output int                             fail_count,
   output int                             outstanding
);
   import ist_pkg::*;

   typedef struct packed {
      logic                  found;
      logic [POSITION_W-1:0] position;
      status_type            status;
      logic [OCC_W-1:0]      occupancy;
   } set_result_type;

   // Shadow copy of the table: live values fill indices 0 .. live_count-1.
   logic [ELEMENT_W-1:0] stored_values [CAPACITY];
   int                   live_count;
   set_result_type       expected_results [$];

   // Applies one request to the shadow table and returns its response.
   function automatic set_result_type predict_request(input logic [ACTION_W-1:0] action,
                                                      input logic [ELEMENT_W-1:0] value);
      set_result_type outcome;
      logic           hit;
      int             where;
      hit   = 1'b0;
      where = 0;
      for (int i = 0; i < live_count; i++) begin
         if (!hit && stored_values[i] == value) begin
            hit   = 1'b1;
            where = i;
         end
      end
      outcome.status = ST_DONE;
      case (action)
         ACT_INSERT: begin
            if (hit) begin
               outcome.status = ST_UNCHANGED;
            end else if (live_count >= CAPACITY) begin
               outcome.status = ST_FULL;
            end else begin
               stored_values[live_count] = value;
               live_count++;
            end
         end
         ACT_REMOVE: begin
            if (!hit) begin
               outcome.status = ST_UNCHANGED;
            end else begin
               // Close the gap so the live values stay packed at the bottom.
               for (int i = where; i < live_count - 1; i++)
                  stored_values[i] = stored_values[i + 1];
               live_count--;
            end
         end
         // Lookup and the unused action code change nothing.
         default: ;
      endcase
      outcome.found     = hit;
      outcome.position  = where[POSITION_W-1:0];
      outcome.occupancy = live_count[OCC_W-1:0];
      return outcome;
   endfunction

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      end
   endtask

   initial begin
      fail_count  = 0;
      outstanding = 0;
      live_count  = 0;
   end

   // Responses are matched before the request of the same edge is predicted.
   always @(posedge clock) begin
      set_result_type want;
      if (reset) begin
         live_count = 0;
         expected_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               fail_count++;
               $display("%0t: response item with none expected, expected nothing, got %h/%h",
                        $time, rsp_tuser, rsp_tdata);
            end else begin
               want = expected_results.pop_front();
               check_field("found", want.found, rsp_tuser[0]);
               check_field("status", want.status, rsp_tuser[2:1]);
               check_field("position", want.position, rsp_tdata[3:0]);
               check_field("occupancy", want.occupancy, rsp_tdata[8:4]);
            end
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(predict_request(req_tuser, req_tdata));
      end
      outstanding <= expected_results.size();
   end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import ist_pkg::*;

   // The action code that the block has no name for; it behaves as a lookup.
   localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;
   localparam int IDLE_LIMIT   = 2000;
   localparam int HOLD_CYCLES  = 300;
   localparam int HOLD_AT      = 400;
   localparam int POOL_SIZE    = 24;
   localparam int PHASES       = 16;
   localparam int PHASE_ITEMS  = 64;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // [31:0] element
   logic [REQ_USER_W-1:0] req_tuser;   // [1:0] action
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [3:0] position, [8:4] occupancy
   logic [RSP_USER_W-1:0] rsp_tuser;   // [0] found, [2:1] status
   int                    fail_count;
   int                    outstanding;
   int                    idle_cycles;
   bit                    send_burst;
   element_type           value_pool [POOL_SIZE];

   integer_set_table DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   set_table_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offers one request item, called at a falling edge, and returns at the
   // falling edge after it was taken.
   task automatic send_request(input logic [ACTION_W-1:0] action, input element_type value);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= action;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Picks an action with a bias toward growing or shrinking the set.
   function automatic logic [ACTION_W-1:0] pick_action(input bit growing);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll >= 95)
         return ACT_SPARE;
      if (roll >= 75)
         return ACT_LOOKUP;
      if (roll < 55)
         return growing ? ACT_INSERT : ACT_REMOVE;
      return growing ? ACT_REMOVE : ACT_INSERT;
   endfunction

   // Request stimulus and the final verdict.
   initial begin
      element_type value;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = ACT_LOOKUP;
      send_burst = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: empty table, extreme values, duplicates and a shift.
      send_request(ACT_LOOKUP, 32'sd0);
      send_request(ACT_REMOVE, 32'sd5);
      send_request(ACT_INSERT, 32'sh8000_0000);
      send_request(ACT_INSERT, 32'sh7FFF_FFFF);
      send_request(ACT_INSERT, -32'sd1);
      send_request(ACT_INSERT, 32'sd0);
      send_request(ACT_INSERT, 32'sh8000_0000);
      send_request(ACT_LOOKUP, 32'sh7FFF_FFFF);
      send_request(ACT_SPARE, -32'sd1);
      send_request(ACT_REMOVE, 32'sh7FFF_FFFF);
      send_request(ACT_LOOKUP, -32'sd1);
      // Fill the table up to its capacity, then try one more value.
      for (int k = 0; k < CAPACITY - 3; k++)
         send_request(ACT_INSERT, 32'sd1 <<< (k + 3));
      send_request(ACT_INSERT, 32'sh5A5A_5A5A);
      send_request(ACT_INSERT, 32'sd0);
      send_request(ACT_REMOVE, 32'sh8000_0000);
      send_request(ACT_LOOKUP, 32'sd1 <<< (CAPACITY - 1));

      // Random part: alternating phases that grow and shrink the set, with
      // values drawn mostly from a small pool so that hits are common.
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase % 2 == 0) begin
            foreach (value_pool[i])
               value_pool[i] = $urandom;
            if ($urandom_range(0, 3) == 0) begin
               value_pool[0] = 32'sh8000_0000;
               value_pool[1] = 32'sh7FFF_FFFF;
            end
         end
         send_burst = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 9) == 0)
               value = $urandom;
            else
               value = value_pool[$urandom_range(0, POOL_SIZE - 1)];
            send_request(pick_action(phase % 2 == 0), value);
         end
      end
      req_tvalid <= 1'b0;

      wait (outstanding == 0);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS integer_set_table");
      end else begin
         $display("FAIL integer_set_table");
      end
      $finish;
   end

   // Response side: random stalls, stretches without stalls, and one long
   // hold-off so the block backs up and stalls its input.
   initial begin
      int  stall;
      int  taken;
      bit  burst;
      rsp_tready = 1'b0;
      taken      = 0;
      burst      = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         stall = burst ? 0 : $urandom_range(0, 8);
         if (taken == HOLD_AT)
            stall = HOLD_CYCLES;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
         if (taken % 50 == 0)
            burst = ($urandom_range(0, 2) == 0);
         @(negedge clock);
      end
   end

   // Watchdog: ends the run when neither channel moves an item for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
         $display("FAIL integer_set_table");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
